// File: sv/hpc_pkg.sv
// Shared types, constants and helper functions of the hodgepodge cell update block.
package hpc_pkg;

  localparam int CELL_BITS = 8;
  localparam int NBR_COUNT = 8;
  localparam int SUM_BITS  = 11;  // eight cells of 255 at most
  localparam int CNT_BITS  = 4;   // counts 0 .. 8
  localparam int RAW_BITS  = CELL_BITS + 1;
  localparam int IN_BITS   = CELL_BITS * (NBR_COUNT + 1);

  typedef logic [CELL_BITS-1:0] cell_t;
  typedef logic [CNT_BITS-1:0]  cnt_t;
  typedef logic [SUM_BITS-1:0]  sum_t;

  localparam cell_t HEALTHY_STATE = cell_t'(1);

  // Divide by nine as a multiply by a rounded-up reciprocal. Exact for sums below 3276.
  localparam int    AVG_SHIFT     = 14;
  localparam sum_t  AVG_MULT      = sum_t'(1821);
  localparam int    AVG_PROD_BITS = 2 * SUM_BITS;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_MAX_STATE        = 2'd0;
  localparam logic [1:0] REG_INFECTED_DIVISOR = 2'd1;
  localparam logic [1:0] REG_ILL_DIVISOR      = 2'd2;
  localparam logic [1:0] REG_GROWTH_STEP      = 2'd3;

  localparam cell_t RST_MAX_STATE        = cell_t'(200);
  localparam cell_t RST_INFECTED_DIVISOR = cell_t'(2);
  localparam cell_t RST_ILL_DIVISOR      = cell_t'(3);
  localparam cell_t RST_GROWTH_STEP      = cell_t'(35);

  typedef struct packed {
    logic ill;
    logic infected;
  } lane_t;

  typedef struct packed {
    sum_t                 sum;
    logic [NBR_COUNT-1:0] ill;
    logic [NBR_COUNT-1:0] infected;
    logic                 center_ill;
    logic                 center_healthy;
  } s1_t;

  typedef struct packed {
    cnt_t  q_infected;
    cnt_t  q_ill;
    cell_t avg;
    logic  center_ill;
    logic  center_healthy;
  } s2_t;

  // Quotient of a small count by a divisor: the number of multiples of the
  // divisor that fit under the count. A divisor of zero acts as one.
  function automatic cnt_t div_count(input cnt_t count, input cell_t k);
    logic [CELL_BITS+CNT_BITS-1:0] kk;
    logic [CELL_BITS+CNT_BITS-1:0] prod;
    cnt_t q;
    kk = (k == '0) ? (CELL_BITS+CNT_BITS)'(1) : (CELL_BITS+CNT_BITS)'(k);
    q  = '0;
    for (int m = 1; m <= NBR_COUNT; m++) begin
      prod = kk * (CELL_BITS+CNT_BITS)'(m);
      if (prod <= (CELL_BITS+CNT_BITS)'(count)) begin
        q = q + cnt_t'(1);
      end
    end
    return q;
  endfunction

  function automatic cnt_t pop_count(input logic [NBR_COUNT-1:0] bits);
    cnt_t c;
    c = '0;
    for (int i = 0; i < NBR_COUNT; i++) begin
      c = c + cnt_t'(bits[i]);
    end
    return c;
  endfunction

endpackage

// File: sv/hpc_lane.sv
// Classifies one neighbour state as ill, infected or neither.
module hpc_lane (
  input  hpc_pkg::cell_t state,
  input  hpc_pkg::cell_t max_state,
  output hpc_pkg::lane_t result
);

  always_comb begin
    result.ill      = (state == max_state);
    result.infected = (state != max_state) && (state > hpc_pkg::HEALTHY_STATE) &&
                      (state < max_state);
  end

endmodule

// File: sv/hpc_merge.sv
// Merges the lane flags into counts and divides the counts and the neighbour sum.
module hpc_merge (
  input  hpc_pkg::s1_t   s1,
  input  hpc_pkg::cell_t infected_divisor,
  input  hpc_pkg::cell_t ill_divisor,
  output hpc_pkg::s2_t   s2
);

  hpc_pkg::cnt_t                                  n_infected;
  hpc_pkg::cnt_t                                  n_ill;
  logic [hpc_pkg::AVG_PROD_BITS-1:0]              avg_prod;

  always_comb begin
    n_infected = hpc_pkg::pop_count(s1.infected);
    n_ill      = hpc_pkg::pop_count(s1.ill);
    avg_prod   = hpc_pkg::AVG_PROD_BITS'(s1.sum) * hpc_pkg::AVG_PROD_BITS'(hpc_pkg::AVG_MULT);

    s2.q_infected     = hpc_pkg::div_count(n_infected, infected_divisor);
    s2.q_ill          = hpc_pkg::div_count(n_ill, ill_divisor);
    s2.avg            = avg_prod[hpc_pkg::AVG_SHIFT +: hpc_pkg::CELL_BITS];
    s2.center_ill     = s1.center_ill;
    s2.center_healthy = s1.center_healthy;
  end

endmodule

// File: sv/hodgepodge_cell_update.sv
// Hodgepodge automaton cell update: eight classifier lanes, merge and divide, select.
// Registers s1_r, s2_r and next_state_r lie between an input beat and its result beat.
// Throughput: one cell per cycle while out_tready is high; each of the three stages holds
// one item and moves on as soon as the stage after it is free, so a waiting result
// does not block new input beats until all stages are full.
// Reset: synchronous, active low; clears the valid flags and loads the register defaults.
module hodgepodge_cell_update (
  input  logic                         clk,
  input  logic                         rst_n,
  // center_state [7:0], neighbour_0 [15:8], ... neighbour_7 [71:64]
  input  logic [hpc_pkg::IN_BITS-1:0]  in_tdata,
  input  logic                         in_tvalid,
  output logic                         in_tready,
  // next_state [7:0]
  output logic [hpc_pkg::CELL_BITS-1:0] out_tdata,
  output logic                         out_tvalid,
  input  logic                         out_tready,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_addr,
  input  logic [hpc_pkg::CELL_BITS-1:0] cfg_wdata
);

  hpc_pkg::cell_t max_state_r;
  hpc_pkg::cell_t infected_divisor_r;
  hpc_pkg::cell_t ill_divisor_r;
  hpc_pkg::cell_t growth_step_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_state_r        <= hpc_pkg::RST_MAX_STATE;
      infected_divisor_r <= hpc_pkg::RST_INFECTED_DIVISOR;
      ill_divisor_r      <= hpc_pkg::RST_ILL_DIVISOR;
      growth_step_r      <= hpc_pkg::RST_GROWTH_STEP;
    end else if (cfg_we) begin
      case (cfg_addr)
        hpc_pkg::REG_MAX_STATE:        max_state_r        <= cfg_wdata;
        hpc_pkg::REG_INFECTED_DIVISOR: infected_divisor_r <= cfg_wdata;
        hpc_pkg::REG_ILL_DIVISOR:      ill_divisor_r      <= cfg_wdata;
        hpc_pkg::REG_GROWTH_STEP:      growth_step_r      <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // Stage handshake: a stage may load when it is empty or its item moves on.
  logic v1_r, v2_r, v3_r;
  logic rdy1, rdy2, rdy3;

  assign rdy3      = !v3_r || out_tready;
  assign rdy2      = !v2_r || rdy3;
  assign rdy1      = !v1_r || rdy2;
  assign in_tready = rdy1;

  // Lanes
  hpc_pkg::cell_t center;
  hpc_pkg::cell_t nbr [hpc_pkg::NBR_COUNT];
  hpc_pkg::lane_t lane_res [hpc_pkg::NBR_COUNT];
  hpc_pkg::s1_t   s1_nxt, s1_r;
  hpc_pkg::s2_t   s2_nxt, s2_r;

  assign center = in_tdata[hpc_pkg::CELL_BITS-1:0];

  for (genvar i = 0; i < hpc_pkg::NBR_COUNT; i++) begin : g_lane
    assign nbr[i] = in_tdata[hpc_pkg::CELL_BITS*(i+1) +: hpc_pkg::CELL_BITS];
    hpc_lane u_lane (
      .state     (nbr[i]),
      .max_state (max_state_r),
      .result    (lane_res[i])
    );
  end

  always_comb begin
    s1_nxt.sum = '0;
    for (int i = 0; i < hpc_pkg::NBR_COUNT; i++) begin
      s1_nxt.sum         = s1_nxt.sum + hpc_pkg::SUM_BITS'(nbr[i]);
      s1_nxt.ill[i]      = lane_res[i].ill;
      s1_nxt.infected[i] = lane_res[i].infected;
    end
    s1_nxt.center_ill     = (center == max_state_r);
    s1_nxt.center_healthy = (center == hpc_pkg::HEALTHY_STATE);
  end

  hpc_merge u_merge (
    .s1               (s1_r),
    .infected_divisor (infected_divisor_r),
    .ill_divisor      (ill_divisor_r),
    .s2               (s2_nxt)
  );

  // Final select and saturation.
  logic [hpc_pkg::RAW_BITS-1:0]  raw;
  hpc_pkg::cell_t                next_state_nxt;
  hpc_pkg::cell_t                next_state_r;

  always_comb begin
    if (s2_r.center_ill) begin
      raw = hpc_pkg::RAW_BITS'(hpc_pkg::HEALTHY_STATE);
    end else if (s2_r.center_healthy) begin
      raw = hpc_pkg::RAW_BITS'(s2_r.q_infected) + hpc_pkg::RAW_BITS'(s2_r.q_ill) +
            hpc_pkg::RAW_BITS'(hpc_pkg::HEALTHY_STATE);
    end else begin
      raw = hpc_pkg::RAW_BITS'(s2_r.avg) + hpc_pkg::RAW_BITS'(growth_step_r);
    end
    if (raw > hpc_pkg::RAW_BITS'(max_state_r)) begin
      next_state_nxt = max_state_r;
    end else begin
      next_state_nxt = raw[hpc_pkg::CELL_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_tvalid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
      if (rdy3) begin
        v3_r <= v2_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1 && in_tvalid) begin
      s1_r <= s1_nxt;
    end
    if (rdy2 && v1_r) begin
      s2_r <= s2_nxt;
    end
    if (rdy3 && v2_r) begin
      next_state_r <= next_state_nxt;
    end
  end

  assign out_tvalid = v3_r;
  assign out_tdata  = next_state_r;

endmodule
